@@ rtl/rvq_pkg.sv @@
// ---------------------------------------------------------------------------
// rvq_pkg
// Shared types, constants and functions of the rotation vector to
// quaternion pipeline.
// ---------------------------------------------------------------------------
package rvq_pkg;

    localparam logic [63:0]        TWO_PI_Q60   = 64'h6487ED5110B4611A;
    localparam logic [63:0]        PI_Q60       = TWO_PI_Q60 >> 1;
    localparam logic [63:0]        HALF_PI_Q60  = TWO_PI_Q60 >> 2;
    localparam logic [63:0]        GAIN_INV_Q62 = 64'd2800459870029452965;
    localparam logic [63:0]        ONE_Q60      = 64'd1 << 60;
    localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
    localparam logic [31:0]        ONE_Q30_MAG  = 32'd1073741824;
    localparam logic [31:0]        LIMIT_RESET  = 32'd28147;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } rvq_rot_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               used_small_angle;
    } rvq_quat_t;

    // Fields that ride along with an item through every cell.
    typedef struct packed {
        rvq_rot_t           rot;
        logic               small_path;
        logic [31:0]        root;
        logic signed [31:0] w;
        logic [2:0]         neg;
    } rvq_side_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } rvq_sqrt_t;

    typedef struct packed {
        logic [63:0] acc;
    } rvq_red_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic               flip;
    } rvq_cordic_t;

    typedef struct packed {
        logic [2:0][63:0] rem;
        logic [2:0][31:0] quo;
    } rvq_div_t;

    // atan(2^-i) in Q60 by a truncated power series; evaluated at elaboration.
    function automatic logic signed [63:0] atan_pow2_q60(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned sh;
        acc = '0;
        if (i == 0) begin
            return signed'(TWO_PI_Q60 >> 3);
        end
        if (i > 60) begin
            return '0;
        end
        for (int unsigned k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh <= 60) begin
                term = (ONE_Q60 >> sh) / 64'(2 * k + 1);
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return signed'(acc);
    endfunction

endpackage

@@ rtl/rotation_vector_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// rotation_vector_to_quaternion
// Exponential map from a fixed-point rotation vector to a unit quaternion.
// ---------------------------------------------------------------------------
// The block takes one rotation vector per clock while the chain is not halted
// and returns one quaternion per item, in order. Each item passes a chain of
// cells: 32 square-root digit cells, one reduction cell per integer bit of
// the half angle plus one, one CORDIC cell per stage and 32 divider cells
// for the three vector lanes. The whole chain moves as one; it halts only
// while its last cell holds an item and the output register is still waiting
// on m_ready, so input is taken while a result waits as long as the last
// cell is empty. The small-angle threshold is written through cfg_wr_en and
// cfg_wr_data.
module rotation_vector_to_quaternion import rvq_pkg::*; #(
    parameter int CORDIC_STAGES   = 32,
    parameter int INPUT_FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  rvq_rot_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rvq_quat_t   m_data
);

    localparam int IP_W    = 31 - INPUT_FRAC_BITS;
    localparam int RED_N   = IP_W + 1;
    localparam int SMALL_S = 29 - INPUT_FRAC_BITS;

    logic        en;
    logic [31:0] limit_reg;

    // Input register with squares.
    logic             a_valid_reg;
    rvq_side_t        a_side_reg;
    logic [2:0][63:0] a_sq_reg;

    logic             sq_v [33];
    rvq_sqrt_t        sq_d [33];
    rvq_side_t        sq_s [33];

    logic             rd_v [RED_N + 1];
    rvq_red_t         rd_d [RED_N + 1];
    rvq_side_t        rd_s [RED_N + 1];

    logic             cd_v [CORDIC_STAGES + 1];
    rvq_cordic_t      cd_d [CORDIC_STAGES + 1];
    rvq_side_t        cd_s [CORDIC_STAGES + 1];

    logic             dv_v [33];
    rvq_div_t         dv_d [33];
    rvq_side_t        dv_s [33];

    logic             p1_valid_reg, p2_valid_reg;
    rvq_side_t        p1_side_reg, p2_side_reg;
    logic [32:0]      p1_tmag_reg;
    logic [2:0][63:0] p2_prod_reg;

    logic             m_valid_reg;
    rvq_quat_t        m_data_reg, m_data_next;

    rvq_side_t        a_side_next, b_side_next, p1_side_next, p2_side_next;
    logic [63:0]      sum_sq;
    rvq_sqrt_t        b_data_next;
    logic [63:0]      red;
    logic             fold_flip;
    rvq_cordic_t      fold_next;
    rvq_cordic_t      last_cd;
    logic [63:0]      xmag, ymag;
    logic [32:0]      wmag, tmag;
    logic [31:0]      wsat;
    logic             wneg, tneg;
    logic [2:0][31:0] rmag;
    rvq_div_t         p3_next;
    logic signed [31:0] rot_v [3];
    logic signed [63:0] small_v;
    logic [31:0]      lane_mag;
    logic signed [31:0] lane_q [3];

    assign en      = !(dv_v[32] && m_valid_reg && !m_ready);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Input stage: three squares side by side.
    always_comb begin
        a_side_next      = '0;
        a_side_next.rot  = s_data;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg  <= a_side_next;
            a_sq_reg[0] <= 64'(s_data.rot_x) * 64'(s_data.rot_x);
            a_sq_reg[1] <= 64'(s_data.rot_y) * 64'(s_data.rot_y);
            a_sq_reg[2] <= 64'(s_data.rot_z) * 64'(s_data.rot_z);
        end
    end

    // Sum of squares and the branch decision.
    always_comb begin
        sum_sq                 = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        b_side_next            = a_side_reg;
        b_side_next.small_path = sum_sq < 64'(limit_reg);
        b_data_next.rem        = sum_sq;
        b_data_next.res        = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_d[0] <= b_data_next;
            sq_s[0] <= b_side_next;
        end
    end

    genvar g;
    for (g = 0; g < 32; g++) begin : g_sqrt
        rvq_sqrt_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_data   (sq_d[g]),
            .in_side   (sq_s[g]),
            .out_valid (sq_v[g + 1]),
            .out_data  (sq_d[g + 1]),
            .out_side  (sq_s[g + 1])
        );
    end

    // The root leaves the square-root chain and travels with the item.
    always_comb begin
        rd_v[0]      = sq_v[32];
        rd_d[0].acc  = '0;
        rd_s[0]      = sq_s[32];
        rd_s[0].root = sq_d[32].res[31:0];
    end

    for (g = 0; g < RED_N; g++) begin : g_red
        rvq_reduce_cell #(
            .BIT   ((g < IP_W) ? IP_W - 1 - g : 0),
            .FRAC  (INPUT_FRAC_BITS),
            .FINAL (g == IP_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rd_v[g]),
            .in_data   (rd_d[g]),
            .in_side   (rd_s[g]),
            .out_valid (rd_v[g + 1]),
            .out_data  (rd_d[g + 1]),
            .out_side  (rd_s[g + 1])
        );
    end

    // Fold the reduced half angle into [-pi/2, pi/2].
    always_comb begin
        red            = rd_d[RED_N].acc;
        fold_flip      = (red > HALF_PI_Q60) && (red < TWO_PI_Q60 - HALF_PI_Q60);
        fold_next.x    = signed'(GAIN_INV_Q62);
        fold_next.y    = '0;
        fold_next.flip = fold_flip;
        if (fold_flip) begin
            fold_next.z = signed'(red - PI_Q60);
        end else if (red >= PI_Q60) begin
            fold_next.z = signed'(red - TWO_PI_Q60);
        end else begin
            fold_next.z = signed'(red);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_d[0] <= fold_next;
            cd_s[0] <= rd_s[RED_N];
        end
    end

    for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        rvq_cordic_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cd_v[g]),
            .in_data   (cd_d[g]),
            .in_side   (cd_s[g]),
            .out_valid (cd_v[g + 1]),
            .out_data  (cd_d[g + 1]),
            .out_side  (cd_s[g + 1])
        );
    end

    // Round cosine to Q30 and sine to Q31; a fold by pi flips both signs.
    always_comb begin
        last_cd   = cd_d[CORDIC_STAGES];
        xmag      = last_cd.x[63] ? 64'(-last_cd.x) : 64'(last_cd.x);
        ymag      = last_cd.y[63] ? 64'(-last_cd.y) : 64'(last_cd.y);
        wmag      = 33'((xmag + (64'd1 << 31)) >> 32);
        tmag      = 33'((ymag + (64'd1 << 30)) >> 31);
        wneg      = last_cd.x[63] ^ last_cd.flip;
        tneg      = last_cd.y[63] ^ last_cd.flip;
        wsat      = (wmag > 33'(ONE_Q30_MAG)) ? ONE_Q30_MAG : wmag[31:0];
        p1_side_next     = cd_s[CORDIC_STAGES];
        p1_side_next.w   = wneg ? -signed'(wsat) : signed'(wsat);
        p1_side_next.neg = {3{tneg}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= p1_side_next;
            p1_tmag_reg <= tmag;
        end
    end

    // Products |t| * |r| for the three lanes.
    always_comb begin
        rmag[0] = p1_side_reg.rot.rot_x[31] ? 32'(-p1_side_reg.rot.rot_x)
                                           : 32'(p1_side_reg.rot.rot_x);
        rmag[1] = p1_side_reg.rot.rot_y[31] ? 32'(-p1_side_reg.rot.rot_y)
                                           : 32'(p1_side_reg.rot.rot_y);
        rmag[2] = p1_side_reg.rot.rot_z[31] ? 32'(-p1_side_reg.rot.rot_z)
                                           : 32'(p1_side_reg.rot.rot_z);
        p2_side_next        = p1_side_reg;
        p2_side_next.neg[0] = p1_side_reg.neg[0] ^ p1_side_reg.rot.rot_x[31];
        p2_side_next.neg[1] = p1_side_reg.neg[1] ^ p1_side_reg.rot.rot_y[31];
        p2_side_next.neg[2] = p1_side_reg.neg[2] ^ p1_side_reg.rot.rot_z[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg <= p2_side_next;
            for (int j = 0; j < 3; j++) begin
                p2_prod_reg[j] <= 64'(p1_tmag_reg * 65'(rmag[j]));
            end
        end
    end

    // Dividend |t|*|r| + A, so the quotient by 2A rounds half up.
    always_comb begin
        p3_next.quo = '0;
        for (int j = 0; j < 3; j++) begin
            p3_next.rem[j] = p2_prod_reg[j] + 64'(p2_side_reg.root);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_d[0] <= p3_next;
            dv_s[0] <= p2_side_reg;
        end
    end

    for (g = 0; g < 32; g++) begin : g_div
        rvq_div_cell #(.BIT(31 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_data   (dv_d[g]),
            .in_side   (dv_s[g]),
            .out_valid (dv_v[g + 1]),
            .out_data  (dv_d[g + 1]),
            .out_side  (dv_s[g + 1])
        );
    end

    // Valid bits of the stages that live in this module.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            sq_v[0]      <= 1'b0;
            cd_v[0]      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            dv_v[0]      <= 1'b0;
        end else if (en) begin
            a_valid_reg  <= s_valid;
            sq_v[0]      <= a_valid_reg;
            cd_v[0]      <= rd_v[RED_N];
            p1_valid_reg <= cd_v[CORDIC_STAGES];
            p2_valid_reg <= p1_valid_reg;
            dv_v[0]      <= p2_valid_reg;
        end
    end

    // Result selection and saturation.
    always_comb begin
        rot_v[0] = dv_s[32].rot.rot_x;
        rot_v[1] = dv_s[32].rot.rot_y;
        rot_v[2] = dv_s[32].rot.rot_z;
        for (int j = 0; j < 3; j++) begin
            small_v  = 64'(rot_v[j]) <<< SMALL_S;
            lane_mag = (dv_d[32].quo[j] > ONE_Q30_MAG) ? ONE_Q30_MAG : dv_d[32].quo[j];
            if (dv_s[32].small_path) begin
                if (small_v > 64'(ONE_Q30)) begin
                    lane_q[j] = ONE_Q30;
                end else if (small_v < -64'(ONE_Q30)) begin
                    lane_q[j] = -ONE_Q30;
                end else begin
                    lane_q[j] = small_v[31:0];
                end
            end else if (dv_s[32].root == '0) begin
                lane_q[j] = '0;
            end else begin
                lane_q[j] = dv_s[32].neg[j] ? -signed'(lane_mag) : signed'(lane_mag);
            end
        end
        m_data_next.quat_w = (dv_s[32].small_path || dv_s[32].root == '0) ? ONE_Q30
                                                                        : dv_s[32].w;
        m_data_next.quat_x           = lane_q[0];
        m_data_next.quat_y           = lane_q[1];
        m_data_next.quat_z           = lane_q[2];
        m_data_next.used_small_angle = dv_s[32].small_path;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= dv_v[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/rvq_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// rvq_sqrt_cell
// One digit step of the integer square root of the squared angle.
// ---------------------------------------------------------------------------
module rvq_sqrt_cell import rvq_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  rvq_sqrt_t in_data,
    input  rvq_side_t in_side,
    output logic      out_valid,
    output rvq_sqrt_t out_data,
    output rvq_side_t out_side
);

    localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

    logic      valid_reg;
    rvq_sqrt_t data_reg, data_next;
    rvq_side_t side_reg;
    logic [63:0] trial;

    always_comb begin
        trial = in_data.res + BIT_VAL;
        if (in_data.rem >= trial) begin
            data_next.rem = in_data.rem - trial;
            data_next.res = (in_data.res >> 1) + BIT_VAL;
        end else begin
            data_next.rem = in_data.rem;
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/rvq_reduce_cell.sv @@
// ---------------------------------------------------------------------------
// rvq_reduce_cell
// One step of the half-angle reduction modulo two pi in Q60.
// ---------------------------------------------------------------------------
module rvq_reduce_cell import rvq_pkg::*; #(
    parameter int BIT   = 0,
    parameter int FRAC  = 24,
    parameter bit FINAL = 1'b0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  rvq_red_t  in_data,
    input  rvq_side_t in_side,
    output logic      out_valid,
    output rvq_red_t  out_data,
    output rvq_side_t out_side
);

    logic      valid_reg;
    rvq_red_t  data_reg, data_next;
    rvq_side_t side_reg;
    logic [63:0] sum, once;

    if (FINAL) begin : g_final
        // The fraction of the half angle joins last; one subtraction suffices.
        always_comb begin
            sum  = in_data.acc + (64'(in_side.root[FRAC:0]) << (59 - FRAC));
            once = sum;
            data_next.acc = (sum >= TWO_PI_Q60) ? sum - TWO_PI_Q60 : sum;
        end
    end else begin : g_bit
        localparam int IDX = BIT + FRAC + 1;
        always_comb begin
            sum  = {in_data.acc[62:0], 1'b0} + (in_side.root[IDX] ? ONE_Q60 : 64'd0);
            once = (sum >= TWO_PI_Q60) ? sum - TWO_PI_Q60 : sum;
            data_next.acc = (once >= TWO_PI_Q60) ? once - TWO_PI_Q60 : once;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/rvq_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// rvq_cordic_cell
// One rotation-mode CORDIC micro-rotation by atan(2^-STEP).
// ---------------------------------------------------------------------------
module rvq_cordic_cell import rvq_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  rvq_cordic_t in_data,
    input  rvq_side_t   in_side,
    output logic        out_valid,
    output rvq_cordic_t out_data,
    output rvq_side_t   out_side
);

    localparam logic signed [63:0] ATAN_Q60 = atan_pow2_q60(STEP);

    logic        valid_reg;
    rvq_cordic_t data_reg, data_next;
    rvq_side_t   side_reg;
    logic signed [63:0] dx, dy;

    always_comb begin
        dx = in_data.y >>> STEP;
        dy = in_data.x >>> STEP;
        data_next.flip = in_data.flip;
        if (!in_data.z[63]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN_Q60;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN_Q60;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/rvq_div_cell.sv @@
// ---------------------------------------------------------------------------
// rvq_div_cell
// One restoring division step for the three vector lanes, divisor 2*A.
// ---------------------------------------------------------------------------
module rvq_div_cell import rvq_pkg::*; #(
    parameter int BIT = 31
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  rvq_div_t  in_data,
    input  rvq_side_t in_side,
    output logic      out_valid,
    output rvq_div_t  out_data,
    output rvq_side_t out_side
);

    logic      valid_reg;
    rvq_div_t  data_reg, data_next;
    rvq_side_t side_reg;
    logic [64:0] den_shift;

    always_comb begin
        den_shift = {32'd0, in_side.root, 1'b0} << BIT;
        data_next = in_data;
        for (int j = 0; j < 3; j++) begin
            if ({1'b0, in_data.rem[j]} >= den_shift) begin
                data_next.rem[j]      = in_data.rem[j] - den_shift[63:0];
                data_next.quo[j][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule
